### hdl/spp_pkg.sv
package spp_pkg;

   localparam int ADDR_BITS = 16;
   localparam int RAM_DEPTH = 2 ** ADDR_BITS;
   localparam int STEP_W    = 6;

   localparam logic [15:0] SEG_MASK    = 16'h000F;
   localparam logic [3:0]  WORD_BYTES  = 4'd2;
   localparam logic [3:0]  MAX_OPERAND = 4'd8;

   // commands
   localparam logic [2:0] CMD_PUSH_OP   = 3'd0;
   localparam logic [2:0] CMD_POP_OP    = 3'd1;
   localparam logic [2:0] CMD_PUSH_LIST = 3'd2;
   localparam logic [2:0] CMD_POP_LIST  = 3'd3;
   localparam logic [2:0] CMD_LOAD_SP   = 3'd4;

   // memory access of a step
   localparam logic [1:0] MEM_NONE = 2'd0;
   localparam logic [1:0] MEM_WR   = 2'd1;
   localparam logic [1:0] MEM_RD   = 2'd2;

   // address offset from the stack pointer
   localparam logic [2:0] ADR_SP  = 3'd0;
   localparam logic [2:0] ADR_M1  = 3'd1;
   localparam logic [2:0] ADR_M2  = 3'd2;
   localparam logic [2:0] ADR_P1  = 3'd3;
   localparam logic [2:0] ADR_CNT = 3'd4;

   // write data source
   localparam logic [1:0] WD_LO   = 2'd0;
   localparam logic [1:0] WD_HI   = 2'd1;
   localparam logic [1:0] WD_OPND = 2'd2;

   // stack pointer operation
   localparam logic [2:0] SP_HOLD    = 3'd0;
   localparam logic [2:0] SP_SUB2    = 3'd1;
   localparam logic [2:0] SP_ADD2    = 3'd2;
   localparam logic [2:0] SP_SUB_ADJ = 3'd3;
   localparam logic [2:0] SP_ADD_ADJ = 3'd4;
   localparam logic [2:0] SP_LOAD    = 3'd5;

   // capture of read data
   localparam logic [1:0] CAP_NONE = 2'd0;
   localparam logic [1:0] CAP_LO   = 2'd1;
   localparam logic [1:0] CAP_WORD = 2'd2;

   // register slots of the push and pop lists
   localparam logic [2:0] SLOT_NONE  = 3'd0;
   localparam logic [2:0] SLOT_EA    = 3'd1;
   localparam logic [2:0] SLOT_PCLNK = 3'd2;
   localparam logic [2:0] SLOT_STAT  = 3'd3;
   localparam logic [2:0] SLOT_LR    = 3'd4;
   localparam logic [2:0] SLOT_LSEG  = 3'd5;
   localparam logic [2:0] SLOT_CSEG  = 3'd6;

   // sequencing
   localparam logic [1:0] JMP_NONE = 2'd0;
   localparam logic [1:0] JMP_SKIP = 2'd1;
   localparam logic [1:0] JMP_LOOP = 2'd2;

   // program entry points
   localparam logic [STEP_W-1:0] ENTRY_PUSH_OP   = 6'd0;
   localparam logic [STEP_W-1:0] ENTRY_POP_OP    = 6'd3;
   localparam logic [STEP_W-1:0] ENTRY_PUSH_LIST = 6'd6;
   localparam logic [STEP_W-1:0] ENTRY_POP_LIST  = 6'd19;
   localparam logic [STEP_W-1:0] ENTRY_LOAD_SP   = 6'd38;
   localparam logic [STEP_W-1:0] ENTRY_UNUSED    = 6'd39;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  operand_size;
      logic [63:0] operand_value;
      logic [3:0]  list_mask;
      logic [15:0] link_in;
      logic [3:0]  link_segment_in;
      logic [15:0] exc_link_in;
      logic [3:0]  exc_segment_in;
      logic [7:0]  exc_status_in;
      logic [15:0] pointer_reg_in;
      logic [15:0] new_sp;
   } req_type;

   typedef struct packed {
      logic [63:0] popped_value;
      logic [15:0] pointer_reg_out;
      logic [15:0] link_out;
      logic [3:0]  link_segment_out;
      logic [7:0]  status_out;
      logic [15:0] pc_out;
      logic [3:0]  code_segment_out;
      logic [3:0]  restored_mask;
      logic [15:0] stack_pointer;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mem;
      logic [2:0]        adr;
      logic [1:0]        wd;
      logic [2:0]        spop;
      logic [1:0]        cap;
      logic              cnt_inc;
      logic [2:0]        slot;
      logic [1:0]        jmp;
      logic [STEP_W-1:0] target;
      logic              done;
   } ucode_type;

   function automatic ucode_type uw(input logic [1:0] mem, input logic [2:0] adr,
                                    input logic [1:0] wd, input logic [2:0] spop,
                                    input logic [1:0] cap, input logic cnt_inc,
                                    input logic [2:0] slot, input logic [1:0] jmp,
                                    input logic [STEP_W-1:0] target, input logic done);
      ucode_type w;
      w.mem     = mem;
      w.adr     = adr;
      w.wd      = wd;
      w.spop    = spop;
      w.cap     = cap;
      w.cnt_inc = cnt_inc;
      w.slot    = slot;
      w.jmp     = jmp;
      w.target  = target;
      w.done    = done;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         // push operand: move sp, then one byte a step
         6'd0:  w = uw(MEM_NONE, ADR_SP,  WD_LO,   SP_SUB_ADJ, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b0);
         6'd1:  w = uw(MEM_WR,   ADR_CNT, WD_OPND, SP_HOLD, CAP_NONE, 1'b1, SLOT_NONE,
                       JMP_LOOP, 6'd1, 1'b0);
         6'd2:  w = uw(MEM_NONE, ADR_SP,  WD_LO,   SP_HOLD, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b1);
         // pop operand: read loop, drain the last byte, then move sp
         6'd3:  w = uw(MEM_RD,   ADR_CNT, WD_LO,   SP_HOLD, CAP_NONE, 1'b1, SLOT_NONE,
                       JMP_LOOP, 6'd3, 1'b0);
         6'd4:  w = uw(MEM_NONE, ADR_SP,  WD_LO,   SP_HOLD, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b0);
         6'd5:  w = uw(MEM_NONE, ADR_SP,  WD_LO,   SP_ADD_ADJ, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b1);
         // push list: high byte at sp-1, then low byte at sp-2 with sp update
         6'd6:  w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_CSEG,
                       JMP_SKIP, 6'd8, 1'b0);
         6'd7:  w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_CSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd8:  w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_PCLNK,
                       JMP_SKIP, 6'd10, 1'b0);
         6'd9:  w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_PCLNK,
                       JMP_NONE, 6'd0, 1'b0);
         6'd10: w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_STAT,
                       JMP_SKIP, 6'd12, 1'b0);
         6'd11: w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_STAT,
                       JMP_NONE, 6'd0, 1'b0);
         6'd12: w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_LSEG,
                       JMP_SKIP, 6'd14, 1'b0);
         6'd13: w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_LSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd14: w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_LR,
                       JMP_SKIP, 6'd16, 1'b0);
         6'd15: w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_LR,
                       JMP_NONE, 6'd0, 1'b0);
         6'd16: w = uw(MEM_WR, ADR_M1, WD_HI, SP_HOLD, CAP_NONE, 1'b0, SLOT_EA,
                       JMP_SKIP, 6'd18, 1'b0);
         6'd17: w = uw(MEM_WR, ADR_M2, WD_LO, SP_SUB2, CAP_NONE, 1'b0, SLOT_EA,
                       JMP_NONE, 6'd0, 1'b0);
         6'd18: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b1);
         // pop list: read low, read high, store word and move sp
         6'd19: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_EA,
                       JMP_SKIP, 6'd22, 1'b0);
         6'd20: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_EA,
                       JMP_NONE, 6'd0, 1'b0);
         6'd21: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_EA,
                       JMP_NONE, 6'd0, 1'b0);
         6'd22: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_LR,
                       JMP_SKIP, 6'd25, 1'b0);
         6'd23: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_LR,
                       JMP_NONE, 6'd0, 1'b0);
         6'd24: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_LR,
                       JMP_NONE, 6'd0, 1'b0);
         6'd25: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_LSEG,
                       JMP_SKIP, 6'd28, 1'b0);
         6'd26: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_LSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd27: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_LSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd28: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_STAT,
                       JMP_SKIP, 6'd31, 1'b0);
         6'd29: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_STAT,
                       JMP_NONE, 6'd0, 1'b0);
         6'd30: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_STAT,
                       JMP_NONE, 6'd0, 1'b0);
         6'd31: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_PCLNK,
                       JMP_SKIP, 6'd34, 1'b0);
         6'd32: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_PCLNK,
                       JMP_NONE, 6'd0, 1'b0);
         6'd33: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_PCLNK,
                       JMP_NONE, 6'd0, 1'b0);
         6'd34: w = uw(MEM_RD,   ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_CSEG,
                       JMP_SKIP, 6'd37, 1'b0);
         6'd35: w = uw(MEM_RD,   ADR_P1, WD_LO, SP_HOLD, CAP_LO,   1'b0, SLOT_CSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd36: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_ADD2, CAP_WORD, 1'b0, SLOT_CSEG,
                       JMP_NONE, 6'd0, 1'b0);
         6'd37: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b1);
         // load stack pointer
         6'd38: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_LOAD, CAP_NONE, 1'b0, SLOT_NONE,
                       JMP_NONE, 6'd0, 1'b1);
         default: w = uw(MEM_NONE, ADR_SP, WD_LO, SP_HOLD, CAP_NONE, 1'b0, SLOT_NONE,
                         JMP_NONE, 6'd0, 1'b1);
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] entry_of(input logic [2:0] command);
      logic [STEP_W-1:0] e;
      unique case (command)
         CMD_PUSH_OP:   e = ENTRY_PUSH_OP;
         CMD_POP_OP:    e = ENTRY_POP_OP;
         CMD_PUSH_LIST: e = ENTRY_PUSH_LIST;
         CMD_POP_LIST:  e = ENTRY_POP_LIST;
         CMD_LOAD_SP:   e = ENTRY_LOAD_SP;
         default:       e = ENTRY_UNUSED;
      endcase
      return e;
   endfunction

endpackage

### hdl/spp_ram.sv
module spp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/stack_push_pop_unit_core.sv
// stack unit, microcoded: one control word per cycle, one byte access per step
// the result strobe is registered from the last step and comes in the cycle after it
// steps: operand push/pop n+3 (n bytes), list push 1 + 2 per word + 1 per skipped slot,
// list pop 1 + 3 per word + 1 per skipped slot, load sp 1; set by the single-port memory
// a new command is taken in the strobe cycle at the earliest, never while one is running
// reset clears sp and the memory model bit; memory keeps its contents; no stall from rsp
module stack_push_pop_unit_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  spp_pkg::req_type req_data,
   output logic            rsp_valid,
   output spp_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   localparam int AW = spp_pkg::ADDR_BITS;
   localparam int SW = spp_pkg::STEP_W;

   logic             busy_ff, busy_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [15:0]      sp_ff, sp_in;
   logic             large_ff, large_in;
   spp_pkg::req_type req_ff, req_in;
   logic [63:0]      data_ff, data_in;
   logic [3:0]       nbytes_ff, nbytes_in;
   logic [3:0]       adj_ff, adj_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             byte_pend_ff, byte_pend_in;
   logic [2:0]       byte_idx_ff, byte_idx_in;
   logic [7:0]       lo_ff, lo_in;
   logic [63:0]      popped_ff, popped_in;
   logic [15:0]      ea_ff, ea_in;
   logic [15:0]      lr_ff, lr_in;
   logic [3:0]       lseg_ff, lseg_in;
   logic [7:0]       psw_ff, psw_in;
   logic [15:0]      pc_ff, pc_in;
   logic [3:0]       cseg_ff, cseg_in;
   logic [3:0]       restored_ff, restored_in;
   logic             rsp_valid_ff, rsp_valid_in;
   spp_pkg::rsp_type rsp_ff, rsp_in;

   spp_pkg::ucode_type uc;
   logic             req_accept;
   logic             slot_en, act, cnt_eq, step_done;
   logic [15:0]      slot_word, pop_word, pop_seg, offset, addr_full;
   logic [3:0]       size_clamp;
   logic             ram_en, ram_we;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_wdata, ram_rdata;

   spp_ram #(
      .WIDTH (8),
      .DEPTH (spp_pkg::RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_accept = start && !busy_ff;
   assign uc         = spp_pkg::ucode_rom(step_ff);
   assign cnt_eq     = (cnt_ff == nbytes_ff);
   assign pop_word   = {ram_rdata, lo_ff};
   assign pop_seg    = pop_word & spp_pkg::SEG_MASK;
   assign size_clamp = (req_data.operand_size > spp_pkg::MAX_OPERAND) ?
                       spp_pkg::MAX_OPERAND : req_data.operand_size;

   // slot enable and push source
   always_comb begin
      unique case (uc.slot)
         spp_pkg::SLOT_EA: begin
            slot_en   = req_ff.list_mask[0];
            slot_word = req_ff.pointer_reg_in;
         end
         spp_pkg::SLOT_PCLNK: begin
            slot_en   = req_ff.list_mask[1];
            slot_word = req_ff.exc_link_in;
         end
         spp_pkg::SLOT_STAT: begin
            slot_en   = req_ff.list_mask[2];
            slot_word = {8'h00, req_ff.exc_status_in};
         end
         spp_pkg::SLOT_LR: begin
            slot_en   = req_ff.list_mask[3];
            slot_word = req_ff.link_in;
         end
         spp_pkg::SLOT_LSEG: begin
            slot_en   = req_ff.list_mask[3] && large_ff;
            slot_word = {12'h000, req_ff.link_segment_in} & spp_pkg::SEG_MASK;
         end
         spp_pkg::SLOT_CSEG: begin
            slot_en   = req_ff.list_mask[1] && large_ff;
            slot_word = {12'h000, req_ff.exc_segment_in} & spp_pkg::SEG_MASK;
         end
         default: begin
            slot_en   = 1'b1;
            slot_word = 16'h0000;
         end
      endcase
   end

   // sequencer: a taken skip or a finished loop suppresses the step's actions
   always_comb begin
      unique case (uc.jmp)
         spp_pkg::JMP_SKIP: begin
            act     = slot_en;
            step_in = slot_en ? step_ff + SW'(1) : uc.target;
         end
         spp_pkg::JMP_LOOP: begin
            act     = !cnt_eq;
            step_in = cnt_eq ? step_ff + SW'(1) : uc.target;
         end
         default: begin
            act     = 1'b1;
            step_in = step_ff + SW'(1);
         end
      endcase
      if (req_accept) begin
         step_in = spp_pkg::entry_of(req_data.command);
      end
   end

   assign step_done = busy_ff && act && uc.done;

   // address and write data
   always_comb begin
      unique case (uc.adr)
         spp_pkg::ADR_M1:  offset = 16'hFFFF;
         spp_pkg::ADR_M2:  offset = 16'hFFFE;
         spp_pkg::ADR_P1:  offset = 16'h0001;
         spp_pkg::ADR_CNT: offset = {12'h000, cnt_ff};
         default:          offset = 16'h0000;
      endcase
      unique case (uc.wd)
         spp_pkg::WD_HI:   ram_wdata = slot_word[15:8];
         spp_pkg::WD_OPND: ram_wdata = data_ff[7:0];
         default:          ram_wdata = slot_word[7:0];
      endcase
   end

   assign addr_full = sp_ff + offset;
   assign ram_addr  = addr_full[AW-1:0];
   assign ram_en    = busy_ff && act && (uc.mem != spp_pkg::MEM_NONE);
   assign ram_we    = ram_en && (uc.mem == spp_pkg::MEM_WR);

   // datapath next state
   always_comb begin
      busy_in      = busy_ff;
      sp_in        = sp_ff;
      large_in     = large_ff;
      req_in       = req_ff;
      data_in      = data_ff;
      nbytes_in    = nbytes_ff;
      adj_in       = adj_ff;
      cnt_in       = cnt_ff;
      byte_pend_in = 1'b0;
      byte_idx_in  = cnt_ff[2:0];
      lo_in        = lo_ff;
      popped_in    = popped_ff;
      ea_in        = ea_ff;
      lr_in        = lr_ff;
      lseg_in      = lseg_ff;
      psw_in       = psw_ff;
      pc_in        = pc_ff;
      cseg_in      = cseg_ff;
      restored_in  = restored_ff;
      rsp_valid_in = step_done;
      rsp_in       = rsp_ff;

      if (csr_wr_en) begin
         large_in = csr_wr_data;
      end

      // byte from the previous operand read
      if (byte_pend_ff) begin
         popped_in[8*byte_idx_ff +: 8] = ram_rdata;
      end

      if (req_accept) begin
         busy_in     = 1'b1;
         req_in      = req_data;
         data_in     = req_data.operand_value;
         nbytes_in   = size_clamp;
         adj_in      = (size_clamp == 4'd1) ? spp_pkg::WORD_BYTES : size_clamp;
         cnt_in      = 4'd0;
         popped_in   = 64'h0;
         ea_in       = 16'h0000;
         lr_in       = 16'h0000;
         lseg_in     = 4'h0;
         psw_in      = 8'h00;
         pc_in       = 16'h0000;
         cseg_in     = 4'h0;
         restored_in = (req_data.command == spp_pkg::CMD_POP_LIST) ?
                       req_data.list_mask : 4'h0;
      end else if (busy_ff && act) begin
         if (uc.cnt_inc) begin
            cnt_in = cnt_ff + 4'd1;
            if (uc.mem == spp_pkg::MEM_WR) begin
               data_in = data_ff >> 8;
            end else begin
               byte_pend_in = 1'b1;
            end
         end
         unique case (uc.spop)
            spp_pkg::SP_SUB2:    sp_in = sp_ff - {12'h000, spp_pkg::WORD_BYTES};
            spp_pkg::SP_ADD2:    sp_in = sp_ff + {12'h000, spp_pkg::WORD_BYTES};
            spp_pkg::SP_SUB_ADJ: sp_in = sp_ff - {12'h000, adj_ff};
            spp_pkg::SP_ADD_ADJ: sp_in = sp_ff + {12'h000, adj_ff};
            spp_pkg::SP_LOAD:    sp_in = req_ff.new_sp;
            default:             sp_in = sp_ff;
         endcase
         unique case (uc.cap)
            spp_pkg::CAP_LO: lo_in = ram_rdata;
            spp_pkg::CAP_WORD: begin
               unique case (uc.slot)
                  spp_pkg::SLOT_EA:    ea_in   = pop_word;
                  spp_pkg::SLOT_PCLNK: pc_in   = pop_word;
                  spp_pkg::SLOT_STAT:  psw_in  = pop_word[7:0];
                  spp_pkg::SLOT_LR:    lr_in   = pop_word;
                  spp_pkg::SLOT_LSEG:  lseg_in = pop_seg[3:0];
                  spp_pkg::SLOT_CSEG:  cseg_in = pop_seg[3:0];
                  default:             ea_in   = ea_ff;
               endcase
            end
            default: lo_in = lo_ff;
         endcase
         if (uc.done) begin
            busy_in = 1'b0;
            rsp_in.popped_value     = popped_ff;
            rsp_in.pointer_reg_out  = ea_ff;
            rsp_in.link_out         = lr_ff;
            rsp_in.link_segment_out = lseg_ff;
            rsp_in.status_out       = psw_ff;
            rsp_in.pc_out           = pc_ff;
            rsp_in.code_segment_out = cseg_ff;
            rsp_in.restored_mask    = restored_ff;
            rsp_in.stack_pointer    = sp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= spp_pkg::ENTRY_UNUSED;
         sp_ff        <= 16'h0000;
         large_ff     <= 1'b0;
         byte_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         sp_ff        <= sp_in;
         large_ff     <= large_in;
         byte_pend_ff <= byte_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      data_ff     <= data_in;
      nbytes_ff   <= nbytes_in;
      adj_ff      <= adj_in;
      cnt_ff      <= cnt_in;
      byte_idx_ff <= byte_idx_in;
      lo_ff       <= lo_in;
      popped_ff   <= popped_in;
      ea_ff       <= ea_in;
      lr_ff       <= lr_in;
      lseg_ff     <= lseg_in;
      psw_ff      <= psw_in;
      pc_ff       <= pc_in;
      cseg_ff     <= cseg_in;
      restored_ff <= restored_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a word is only reported after the sequencer has run
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy_ff))
      else $error("result strobe without a running command");

   a_wr_only_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> busy_ff)
      else $error("stack memory written while idle");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= nbytes_ff))
      else $error("byte counter ran past the operand size");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("command accepted but sequencer not running");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_done |=> (!busy_ff && rsp_valid_ff))
      else $error("final step did not release busy with a strobe");

endmodule
